// ===== hdl/eatbv_pkg.sv =====
// shared types and constants for the euler angle to basis vector pipeline
// no dependencies
package eatbv_pkg;

   parameter int FULL_TURN     = 46080;
   parameter int HALF_TURN     = 23040;
   parameter int QUARTER_TURN  = 11520;
   parameter int CORDIC_STEPS  = 20;
   parameter int CORDIC_GAIN   = 652032874;
   parameter int Q30_SHIFT     = 30;
   parameter int TRIG_WIDTH    = 32;
   parameter int CORDIC_WIDTH  = 33;
   parameter int ZANGLE_WIDTH  = 26;
   parameter int ZSCALE_SHIFT  = 9;
   parameter int REM_WIDTH     = 18;
   parameter int QUOT_WIDTH    = 10;
   parameter int RECIP_WIDTH   = 26;
   parameter int RECIP_SHIFT   = 40;
   parameter int RECIP         = 23860930;
   parameter int PROD_WIDTH    = 64;
   parameter int NUM_OUT       = 9;

   typedef logic signed [TRIG_WIDTH-1:0] trig_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;

   // atan(2^-i) in degrees times 65536
   function automatic logic signed [ZANGLE_WIDTH-1:0] atan_step(input int step);
      logic signed [ZANGLE_WIDTH-1:0] val;
      case (step)
         0:  val = 26'sd2949120;
         1:  val = 26'sd1740967;
         2:  val = 26'sd919879;
         3:  val = 26'sd466945;
         4:  val = 26'sd234379;
         5:  val = 26'sd117266;
         6:  val = 26'sd58666;
         7:  val = 26'sd29335;
         8:  val = 26'sd14668;
         9:  val = 26'sd7334;
         10: val = 26'sd3667;
         11: val = 26'sd1833;
         12: val = 26'sd917;
         13: val = 26'sd458;
         14: val = 26'sd229;
         15: val = 26'sd115;
         16: val = 26'sd57;
         17: val = 26'sd29;
         18: val = 26'sd14;
         19: val = 26'sd7;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== hdl/eatbv_cordic_step.sv =====
// one registered cordic rotation step
// depends on eatbv_pkg
module eatbv_cordic_step #(
   parameter int STEP = 0
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       src_valid,
   input  logic signed [eatbv_pkg::CORDIC_WIDTH-1:0]  src_x,
   input  logic signed [eatbv_pkg::CORDIC_WIDTH-1:0]  src_y,
   input  logic signed [eatbv_pkg::ZANGLE_WIDTH-1:0]  src_z,
   input  logic                                       src_neg,
   output logic                                       dst_valid,
   output logic signed [eatbv_pkg::CORDIC_WIDTH-1:0]  dst_x,
   output logic signed [eatbv_pkg::CORDIC_WIDTH-1:0]  dst_y,
   output logic signed [eatbv_pkg::ZANGLE_WIDTH-1:0]  dst_z,
   output logic                                       dst_neg
);

   localparam logic signed [eatbv_pkg::ZANGLE_WIDTH-1:0] ATAN = eatbv_pkg::atan_step(STEP);

   logic signed [eatbv_pkg::CORDIC_WIDTH-1:0] dx, dy, x_in, x_ff, y_in, y_ff;
   logic signed [eatbv_pkg::ZANGLE_WIDTH-1:0] z_in, z_ff;
   logic valid_ff, neg_ff;

   always_comb begin
      dx = src_y >>> STEP;
      dy = src_x >>> STEP;
      if (src_z >= 0) begin
         x_in = src_x - dx;
         y_in = src_y + dy;
         z_in = src_z - ATAN;
      end else begin
         x_in = src_x + dx;
         y_in = src_y - dy;
         z_in = src_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= src_neg;
   end

   assign dst_valid = valid_ff;
   assign dst_x     = x_ff;
   assign dst_y     = y_ff;
   assign dst_z     = z_ff;
   assign dst_neg   = neg_ff;

endmodule

// ===== hdl/eatbv_sincos.sv =====
// pipelined sine and cosine of an angle in degrees times 128, Q2.30 results
// depends on eatbv_pkg and eatbv_cordic_step
module eatbv_sincos #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          src_valid,
   input  logic signed [ANGLE_WIDTH-1:0] src_angle,
   output logic                          dst_valid,
   output eatbv_pkg::trig_type           dst_sin,
   output eatbv_pkg::trig_type           dst_cos
);

   localparam int PW = ANGLE_WIDTH + eatbv_pkg::RECIP_WIDTH;
   localparam int RW = eatbv_pkg::REM_WIDTH;
   localparam int XW = eatbv_pkg::CORDIC_WIDTH;
   localparam int ZW = eatbv_pkg::ZANGLE_WIDTH;
   localparam int NS = eatbv_pkg::CORDIC_STEPS;

   // reduction stage 1: reciprocal product
   logic signed [PW-1:0] prod_in, prod_ff;
   logic signed [ANGLE_WIDTH-1:0] angle_ff;
   logic valid1_ff;

   assign prod_in = PW'(src_angle) * PW'(eatbv_pkg::RECIP);

   // reduction stage 2: raw remainder
   logic signed [PW-1:0] quot_full;
   logic signed [eatbv_pkg::QUOT_WIDTH-1:0] quot;
   logic signed [31:0] rem_wide;
   logic signed [RW-1:0] rem_in, rem_ff;
   logic valid2_ff;

   assign quot_full = prod_ff >>> eatbv_pkg::RECIP_SHIFT;
   assign quot      = quot_full[eatbv_pkg::QUOT_WIDTH-1:0];
   assign rem_wide  = 32'(angle_ff) - 32'(quot) * 32'(eatbv_pkg::FULL_TURN);
   assign rem_in    = rem_wide[RW-1:0];

   // reduction stage 3: into (-180, 180]
   logic signed [RW-1:0] pos_rem, red_in, red_ff;
   logic valid3_ff;

   always_comb begin
      if (rem_ff < 0) begin
         pos_rem = rem_ff + RW'(eatbv_pkg::FULL_TURN);
      end else if (rem_ff >= RW'(eatbv_pkg::FULL_TURN)) begin
         pos_rem = rem_ff - RW'(eatbv_pkg::FULL_TURN);
      end else begin
         pos_rem = rem_ff;
      end
      if (pos_rem > RW'(eatbv_pkg::HALF_TURN)) begin
         red_in = pos_rem - RW'(eatbv_pkg::FULL_TURN);
      end else begin
         red_in = pos_rem;
      end
   end

   // reduction stage 4: fold into [-90, 90]
   logic signed [RW-1:0] fold;
   logic fold_neg;
   logic signed [ZW-1:0] z0_in;

   always_comb begin
      if (red_ff > RW'(eatbv_pkg::QUARTER_TURN)) begin
         fold     = RW'(eatbv_pkg::HALF_TURN) - red_ff;
         fold_neg = 1'b1;
      end else if (red_ff < -RW'(eatbv_pkg::QUARTER_TURN)) begin
         fold     = -RW'(eatbv_pkg::HALF_TURN) - red_ff;
         fold_neg = 1'b1;
      end else begin
         fold     = red_ff;
         fold_neg = 1'b0;
      end
      z0_in = ZW'(fold) <<< eatbv_pkg::ZSCALE_SHIFT;
   end

   logic signed [XW-1:0] cx [NS+1];
   logic signed [XW-1:0] cy [NS+1];
   logic signed [ZW-1:0] cz [NS+1];
   logic cneg [NS+1];
   logic cvalid [NS+1];
   logic signed [ZW-1:0] z0_ff;
   logic neg0_ff, valid4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         valid1_ff <= src_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      angle_ff <= src_angle;
      rem_ff   <= rem_in;
      red_ff   <= red_in;
      z0_ff    <= z0_in;
      neg0_ff  <= fold_neg;
   end

   assign cx[0]     = XW'(eatbv_pkg::CORDIC_GAIN);
   assign cy[0]     = '0;
   assign cz[0]     = z0_ff;
   assign cneg[0]   = neg0_ff;
   assign cvalid[0] = valid4_ff;

   for (genvar k = 0; k < NS; k++) begin : g_step
      eatbv_cordic_step #(
         .STEP (k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .src_valid (cvalid[k]),
         .src_x     (cx[k]),
         .src_y     (cy[k]),
         .src_z     (cz[k]),
         .src_neg   (cneg[k]),
         .dst_valid (cvalid[k+1]),
         .dst_x     (cx[k+1]),
         .dst_y     (cy[k+1]),
         .dst_z     (cz[k+1]),
         .dst_neg   (cneg[k+1])
      );
   end

   // clamp to +-1.0 and apply the fold sign
   localparam logic signed [XW-1:0] ONE = XW'(64'sd1 <<< eatbv_pkg::Q30_SHIFT);
   logic signed [XW-1:0] xc, yc;
   eatbv_pkg::trig_type sin_in, sin_ff, cos_in, cos_ff;
   logic valid5_ff;

   always_comb begin
      if (cx[NS] > ONE) begin
         xc = ONE;
      end else if (cx[NS] < -ONE) begin
         xc = -ONE;
      end else begin
         xc = cx[NS];
      end
      if (cy[NS] > ONE) begin
         yc = ONE;
      end else if (cy[NS] < -ONE) begin
         yc = -ONE;
      end else begin
         yc = cy[NS];
      end
      sin_in = yc[eatbv_pkg::TRIG_WIDTH-1:0];
      cos_in = cneg[NS] ? -xc[eatbv_pkg::TRIG_WIDTH-1:0] : xc[eatbv_pkg::TRIG_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid5_ff <= 1'b0;
      end else begin
         valid5_ff <= cvalid[NS];
      end
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign dst_valid = valid5_ff;
   assign dst_sin   = sin_ff;
   assign dst_cos   = cos_ff;

endmodule

// ===== hdl/eatbv_combine.sv =====
// product, sum, rounding and saturation stages for the nine components
// depends on eatbv_pkg
module eatbv_combine #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              src_valid,
   input  eatbv_pkg::trig_type               src_sp,
   input  eatbv_pkg::trig_type               src_cp,
   input  eatbv_pkg::trig_type               src_sy,
   input  eatbv_pkg::trig_type               src_cy,
   input  eatbv_pkg::trig_type               src_sr,
   input  eatbv_pkg::trig_type               src_cr,
   output logic                              dst_valid,
   output logic signed [COMPONENT_WIDTH-1:0] dst_comp [eatbv_pkg::NUM_OUT]
);

   localparam int CW        = COMPONENT_WIDTH;
   localparam int TW        = eatbv_pkg::TRIG_WIDTH;
   localparam int PW        = eatbv_pkg::PROD_WIDTH;
   localparam int NO        = eatbv_pkg::NUM_OUT;
   localparam int OUT_SHIFT = 62 - COMPONENT_WIDTH;
   localparam eatbv_pkg::prod_type OUT_ROUND = PW'(64'sd1 <<< (OUT_SHIFT - 1));
   localparam eatbv_pkg::prod_type OUT_LIMIT = PW'(64'sd1 <<< (COMPONENT_WIDTH - 2));
   localparam eatbv_pkg::prod_type Q30_ROUND = PW'(64'sd1 <<< (eatbv_pkg::Q30_SHIFT - 1));

   // stage a: two-factor products
   eatbv_pkg::prod_type cpcy_a_ff, cpsy_a_ff, crsy_a_ff, crcy_a_ff, srcp_a_ff;
   eatbv_pkg::prod_type srsy_a_ff, srcy_a_ff, crcp_a_ff, srsp_a_ff, crsp_a_ff;
   eatbv_pkg::trig_type sp_a_ff, sy_a_ff, cy_a_ff;
   logic valid_a_ff;

   always_ff @(posedge clock) begin
      cpcy_a_ff <= src_cp * src_cy;
      cpsy_a_ff <= src_cp * src_sy;
      crsy_a_ff <= src_cr * src_sy;
      crcy_a_ff <= src_cr * src_cy;
      srcp_a_ff <= src_sr * src_cp;
      srsy_a_ff <= src_sr * src_sy;
      srcy_a_ff <= src_sr * src_cy;
      crcp_a_ff <= src_cr * src_cp;
      srsp_a_ff <= src_sr * src_sp;
      crsp_a_ff <= src_cr * src_sp;
      sp_a_ff   <= src_sp;
      sy_a_ff   <= src_sy;
      cy_a_ff   <= src_cy;
   end

   // stage b: round the shared products back to q30
   eatbv_pkg::prod_type srsp_r, crsp_r;
   eatbv_pkg::trig_type srsp_b_in, crsp_b_in, srsp_b_ff, crsp_b_ff;
   eatbv_pkg::prod_type cpcy_b_ff, cpsy_b_ff, crsy_b_ff, crcy_b_ff, srcp_b_ff;
   eatbv_pkg::prod_type srsy_b_ff, srcy_b_ff, crcp_b_ff;
   eatbv_pkg::trig_type sp_b_ff, sy_b_ff, cy_b_ff;
   logic valid_b_ff;

   assign srsp_r    = (srsp_a_ff + Q30_ROUND) >>> eatbv_pkg::Q30_SHIFT;
   assign crsp_r    = (crsp_a_ff + Q30_ROUND) >>> eatbv_pkg::Q30_SHIFT;
   assign srsp_b_in = srsp_r[TW-1:0];
   assign crsp_b_in = crsp_r[TW-1:0];

   always_ff @(posedge clock) begin
      srsp_b_ff <= srsp_b_in;
      crsp_b_ff <= crsp_b_in;
      cpcy_b_ff <= cpcy_a_ff;
      cpsy_b_ff <= cpsy_a_ff;
      crsy_b_ff <= crsy_a_ff;
      crcy_b_ff <= crcy_a_ff;
      srcp_b_ff <= srcp_a_ff;
      srsy_b_ff <= srsy_a_ff;
      srcy_b_ff <= srcy_a_ff;
      crcp_b_ff <= crcp_a_ff;
      sp_b_ff   <= sp_a_ff;
      sy_b_ff   <= sy_a_ff;
      cy_b_ff   <= cy_a_ff;
   end

   // stage c: third-factor products
   eatbv_pkg::prod_type t1_c_ff, t2_c_ff, t3_c_ff, t4_c_ff;
   eatbv_pkg::prod_type cpcy_c_ff, cpsy_c_ff, crsy_c_ff, crcy_c_ff, srcp_c_ff;
   eatbv_pkg::prod_type srsy_c_ff, srcy_c_ff, crcp_c_ff;
   eatbv_pkg::trig_type sp_c_ff;
   logic valid_c_ff;

   always_ff @(posedge clock) begin
      t1_c_ff   <= srsp_b_ff * cy_b_ff;
      t2_c_ff   <= srsp_b_ff * sy_b_ff;
      t3_c_ff   <= crsp_b_ff * cy_b_ff;
      t4_c_ff   <= crsp_b_ff * sy_b_ff;
      cpcy_c_ff <= cpcy_b_ff;
      cpsy_c_ff <= cpsy_b_ff;
      crsy_c_ff <= crsy_b_ff;
      crcy_c_ff <= crcy_b_ff;
      srcp_c_ff <= srcp_b_ff;
      srsy_c_ff <= srsy_b_ff;
      srcy_c_ff <= srcy_b_ff;
      crcp_c_ff <= crcp_b_ff;
      sp_c_ff   <= sp_b_ff;
   end

   // stage d: q60 sums
   eatbv_pkg::prod_type sum_in [NO];
   eatbv_pkg::prod_type sum_ff [NO];
   logic valid_d_ff;

   always_comb begin
      sum_in[0] = cpcy_c_ff;
      sum_in[1] = cpsy_c_ff;
      sum_in[2] = -(PW'(sp_c_ff) <<< eatbv_pkg::Q30_SHIFT);
      sum_in[3] = crsy_c_ff - t1_c_ff;
      sum_in[4] = -t2_c_ff - crcy_c_ff;
      sum_in[5] = -srcp_c_ff;
      sum_in[6] = t3_c_ff + srsy_c_ff;
      sum_in[7] = t4_c_ff - srcy_c_ff;
      sum_in[8] = crcp_c_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NO; i++) begin
         sum_ff[i] <= sum_in[i];
      end
   end

   // stage e: round and saturate
   eatbv_pkg::prod_type rnd [NO];
   eatbv_pkg::prod_type sat [NO];
   logic signed [CW-1:0] comp_in [NO];
   logic signed [CW-1:0] comp_ff [NO];
   logic valid_e_ff;

   always_comb begin
      for (int i = 0; i < NO; i++) begin
         rnd[i] = (sum_ff[i] + OUT_ROUND) >>> OUT_SHIFT;
         if (rnd[i] > OUT_LIMIT) begin
            sat[i] = OUT_LIMIT;
         end else if (rnd[i] < -OUT_LIMIT) begin
            sat[i] = -OUT_LIMIT;
         end else begin
            sat[i] = rnd[i];
         end
         comp_in[i] = sat[i][CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NO; i++) begin
         comp_ff[i] <= comp_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
         valid_e_ff <= 1'b0;
      end else begin
         valid_a_ff <= src_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
         valid_d_ff <= valid_c_ff;
         valid_e_ff <= valid_d_ff;
      end
   end

   assign dst_valid = valid_e_ff;
   assign dst_comp  = comp_ff;

endmodule

// ===== hdl/euler_angles_to_basis_vectors.sv =====
// pitch, yaw and roll to forward, right and up vectors, fully pipelined
// registered path: sincos reduction, cordic and clamp, then combine stages a to e
// throughput: one beat per cycle, busy stays low, set by the 20-step cordic pipeline
// results are a one-cycle strobe; the receiver cannot stall
// synchronous active-high reset clears all valid bits; payload is not reset
module euler_angles_to_basis_vectors #(
   parameter int ANGLE_WIDTH     = 16,
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [ANGLE_WIDTH-1:0]     req_pitch_deg,
   input  logic signed [ANGLE_WIDTH-1:0]     req_yaw_deg,
   input  logic signed [ANGLE_WIDTH-1:0]     req_roll_deg,
   output logic                              rsp_valid,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_fwd_x,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_fwd_y,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_fwd_z,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_right_x,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_right_y,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_right_z,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_up_x,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_up_y,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_up_z
);

   logic accept;
   logic p_valid, y_valid, r_valid;
   eatbv_pkg::trig_type sp, cp, sy, cy, sr, cr;
   logic signed [COMPONENT_WIDTH-1:0] comp [eatbv_pkg::NUM_OUT];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   eatbv_sincos #(.ANGLE_WIDTH (ANGLE_WIDTH)) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .src_valid (accept),
      .src_angle (req_pitch_deg),
      .dst_valid (p_valid),
      .dst_sin   (sp),
      .dst_cos   (cp)
   );

   eatbv_sincos #(.ANGLE_WIDTH (ANGLE_WIDTH)) u_yaw (
      .clock     (clock),
      .reset     (reset),
      .src_valid (accept),
      .src_angle (req_yaw_deg),
      .dst_valid (y_valid),
      .dst_sin   (sy),
      .dst_cos   (cy)
   );

   eatbv_sincos #(.ANGLE_WIDTH (ANGLE_WIDTH)) u_roll (
      .clock     (clock),
      .reset     (reset),
      .src_valid (accept),
      .src_angle (req_roll_deg),
      .dst_valid (r_valid),
      .dst_sin   (sr),
      .dst_cos   (cr)
   );

   eatbv_combine #(.COMPONENT_WIDTH (COMPONENT_WIDTH)) u_combine (
      .clock     (clock),
      .reset     (reset),
      .src_valid (p_valid && y_valid && r_valid),
      .src_sp    (sp),
      .src_cp    (cp),
      .src_sy    (sy),
      .src_cy    (cy),
      .src_sr    (sr),
      .src_cr    (cr),
      .dst_valid (rsp_valid),
      .dst_comp  (comp)
   );

   assign rsp_fwd_x   = comp[0];
   assign rsp_fwd_y   = comp[1];
   assign rsp_fwd_z   = comp[2];
   assign rsp_right_x = comp[3];
   assign rsp_right_y = comp[4];
   assign rsp_right_z = comp[5];
   assign rsp_up_x    = comp[6];
   assign rsp_up_y    = comp[7];
   assign rsp_up_z    = comp[8];

endmodule

// ===== test/euler_angles_to_basis_vectors_tb.sv =====
// self-checking testbench for euler_angles_to_basis_vectors: directed table, then random beats
// predicts results with a local cordic model unless a row gives its own basis; depends on eatbv_pkg and the block
`timescale 1ns / 1ps

module euler_angles_to_basis_vectors_tb;

   localparam int AW = 16;
   localparam int CW = 16;
   localparam int NUM_RANDOM = 2000;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 40;

   typedef logic signed [AW-1:0] angle_type;
   typedef logic signed [CW-1:0] comp_type;

   typedef struct packed {
      comp_type fwd_x, fwd_y, fwd_z;
      comp_type right_x, right_y, right_z;
      comp_type up_x, up_y, up_z;
   } basis_type;

   typedef struct {
      angle_type pitch, yaw, roll;
      bit        typed;
      basis_type vec;
   } stim_row_type;

   localparam comp_type ONE = comp_type'(1 << (CW - 2));
   localparam comp_type NEG_ONE = -ONE;

   logic      clock = 0;
   logic      reset = 1;
   logic      start = 0;
   logic      busy;
   angle_type req_pitch_deg = '0, req_yaw_deg = '0, req_roll_deg = '0;
   logic      rsp_valid;
   comp_type  rsp_fwd_x, rsp_fwd_y, rsp_fwd_z, rsp_right_x, rsp_right_y, rsp_right_z;
   comp_type  rsp_up_x, rsp_up_y, rsp_up_z;

   basis_type pending_basis[$];
   int        fail_count = 0;
   longint    cycle_count = 0;

   always #5 clock = ~clock;

   euler_angles_to_basis_vectors #(.ANGLE_WIDTH(AW), .COMPONENT_WIDTH(CW)) dut (.*);

   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic void angle_sin_cos(angle_type a, output longint s, output longint c);
      longint r, x, y, z, dx, dy;
      bit     flip;
      r = longint'(a) % eatbv_pkg::FULL_TURN;
      flip = 0;
      x = eatbv_pkg::CORDIC_GAIN;
      y = 0;
      if (r < 0) r += eatbv_pkg::FULL_TURN;
      if (r > eatbv_pkg::HALF_TURN) r -= eatbv_pkg::FULL_TURN;
      if (r > eatbv_pkg::QUARTER_TURN) begin
         r = eatbv_pkg::HALF_TURN - r;
         flip = 1;
      end else if (r < -eatbv_pkg::QUARTER_TURN) begin
         r = -eatbv_pkg::HALF_TURN - r;
         flip = 1;
      end
      z = r * 512;
      for (int i = 0; i < eatbv_pkg::CORDIC_STEPS; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(eatbv_pkg::atan_step(i));
         end else begin
            x += dx; y -= dy; z += longint'(eatbv_pkg::atan_step(i));
         end
      end
      x = clamp(x, 64'sd1 << 30);
      y = clamp(y, 64'sd1 << 30);
      s = y;
      c = flip ? -x : x;
   endfunction

   function automatic longint triple(longint a, longint b, longint c);
      return fshift(a * b + (64'sd1 << 29), 30) * c;
   endfunction

   function automatic comp_type to_comp(longint q60);
      int     sh;
      longint v;
      sh = 62 - CW;
      v = fshift(q60 + (64'sd1 << (sh - 1)), sh);
      return comp_type'(clamp(v, 64'sd1 << (CW - 2)));
   endfunction

   function automatic basis_type predict_basis(angle_type p, angle_type y, angle_type r);
      longint    sp, cp, sy, cy, sr, cr;
      basis_type b;
      angle_sin_cos(p, sp, cp);
      angle_sin_cos(y, sy, cy);
      angle_sin_cos(r, sr, cr);
      b.fwd_x   = to_comp(cp * cy);
      b.fwd_y   = to_comp(cp * sy);
      b.fwd_z   = to_comp(-sp * (64'sd1 << 30));
      b.right_x = to_comp(-triple(sr, sp, cy) + cr * sy);
      b.right_y = to_comp(-triple(sr, sp, sy) - cr * cy);
      b.right_z = to_comp(-sr * cp);
      b.up_x    = to_comp(triple(cr, sp, cy) + sr * sy);
      b.up_y    = to_comp(triple(cr, sp, sy) - sr * cy);
      b.up_z    = to_comp(cr * cp);
      return b;
   endfunction

   task automatic check_field(string name, comp_type exp_v, comp_type act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %0d actual %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      basis_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_basis.size() == 0) begin
            $error("result beat with nothing expected");
            fail_count++;
         end else begin
            e = pending_basis.pop_front();
            check_field("fwd_x", e.fwd_x, rsp_fwd_x);
            check_field("fwd_y", e.fwd_y, rsp_fwd_y);
            check_field("fwd_z", e.fwd_z, rsp_fwd_z);
            check_field("right_x", e.right_x, rsp_right_x);
            check_field("right_y", e.right_y, rsp_right_y);
            check_field("right_z", e.right_z, rsp_right_z);
            check_field("up_x", e.up_x, rsp_up_x);
            check_field("up_y", e.up_y, rsp_up_y);
            check_field("up_z", e.up_z, rsp_up_z);
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("euler_angles_to_basis_vectors_tb NOT OK");
         $finish;
      end
   end

   int burst_left = 0;
   int gap_left = 0;

   // holds start high across back-to-back beats, only drops it for a gap
   task automatic send_beat(angle_type p, angle_type y, angle_type r, bit typed,
                            basis_type vec);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
         start <= 0;
         repeat (gap_left) @(posedge clock);
         gap_left = 0;
      end
      burst_left--;
      start <= 1;
      req_pitch_deg <= p;
      req_yaw_deg <= y;
      req_roll_deg <= r;
      do @(posedge clock); while (busy);
      pending_basis.push_back(typed ? vec : predict_basis(p, y, r));
   endtask

   function automatic angle_type pick_angle();
      case ($urandom_range(0, 5))
         0: return angle_type'($urandom_range(0, 8) * eatbv_pkg::QUARTER_TURN / 2
                               - 2 * eatbv_pkg::HALF_TURN / 2);
         1: return angle_type'($urandom_range(0, 65535));
         2: return angle_type'(int'($urandom_range(0, 2 * eatbv_pkg::HALF_TURN))
                               - eatbv_pkg::HALF_TURN);
         3: return $urandom_range(0, 1) ? 16'sh7fff - angle_type'($urandom_range(0, 3))
                                        : 16'sh8000 + angle_type'($urandom_range(0, 3));
         default: return angle_type'(int'($urandom_range(0, 2 * eatbv_pkg::QUARTER_TURN))
                                     - eatbv_pkg::QUARTER_TURN);
      endcase
   endfunction

   stim_row_type dir_rows[$];

   function automatic stim_row_type row(int p, int y, int r, bit typed = 0,
                                        basis_type vec = '0);
      stim_row_type s;
      s.pitch = angle_type'(p);
      s.yaw = angle_type'(y);
      s.roll = angle_type'(r);
      s.typed = typed;
      s.vec = vec;
      return s;
   endfunction

   initial begin
      basis_type ident;
      ident = '{fwd_x: ONE, fwd_y: 0, fwd_z: 0, right_x: 0, right_y: NEG_ONE,
                right_z: 0, up_x: 0, up_y: 0, up_z: ONE};
      dir_rows.push_back(row(0, 0, 0, 1, ident));
      dir_rows.push_back(row(0, 0, 0));
      dir_rows.push_back(row(eatbv_pkg::QUARTER_TURN, 0, 0));
      dir_rows.push_back(row(-eatbv_pkg::QUARTER_TURN, 0, 0));
      dir_rows.push_back(row(eatbv_pkg::HALF_TURN, 0, 0));
      dir_rows.push_back(row(-eatbv_pkg::HALF_TURN, 0, 0));
      dir_rows.push_back(row(0, eatbv_pkg::QUARTER_TURN, 0));
      dir_rows.push_back(row(0, eatbv_pkg::HALF_TURN, 0));
      dir_rows.push_back(row(0, 0, eatbv_pkg::QUARTER_TURN));
      dir_rows.push_back(row(0, 0, -eatbv_pkg::HALF_TURN));
      dir_rows.push_back(row(32767, 32767, 32767));
      dir_rows.push_back(row(-32768, -32768, -32768));
      dir_rows.push_back(row(-1, -1, -1));
      dir_rows.push_back(row(1, 1, 1));
      dir_rows.push_back(row(eatbv_pkg::QUARTER_TURN + 1, eatbv_pkg::QUARTER_TURN - 1,
                             -eatbv_pkg::QUARTER_TURN - 1));
      dir_rows.push_back(row(eatbv_pkg::HALF_TURN + 1, eatbv_pkg::HALF_TURN - 1,
                             -eatbv_pkg::HALF_TURN + 1));
      dir_rows.push_back(row(5760, 3840, 1920));
      dir_rows.push_back(row(-5760, 17280, -28800));
      dir_rows.push_back(row(32767, -32768, 0));

      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (dir_rows[i])
         send_beat(dir_rows[i].pitch, dir_rows[i].yaw, dir_rows[i].roll,
                   dir_rows[i].typed, dir_rows[i].vec);
      for (int n = 0; n < NUM_RANDOM; n++)
         send_beat(pick_angle(), pick_angle(), pick_angle(), 0, '0);
      start <= 0;
      while (pending_basis.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("euler_angles_to_basis_vectors_tb OK");
      else
         $display("euler_angles_to_basis_vectors_tb NOT OK");
      $finish;
   end

endmodule
